### design/brlp_pkg.sv
// shared types and constants for the board record line parser
// no dependencies; used by every module of the block
package brlp_pkg;

  localparam int BOARD_SQUARES = 64;
  localparam int BOARD_W       = 64;
  localparam int IDX_W         = $clog2(BOARD_W);
  localparam int FLEN_W        = 7;

  localparam logic [FLEN_W-1:0] BOARD_LEN = FLEN_W'(BOARD_SQUARES);
  localparam logic [FLEN_W-1:0] FLEN_SAT  = FLEN_W'(BOARD_SQUARES + 1);

  localparam logic [7:0] CH_B    = 8'h62;
  localparam logic [7:0] CH_W    = 8'h77;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_SEP  = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_NUL  = 8'h00;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_KEY  = 2'd0,
    KIND_DESC = 2'd1,
    KIND_REC  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_ENTRY      = 3'd0,
    ST_NOT_ENTRY  = 3'd1,
    ST_INCOMPLETE = 3'd2,
    ST_BOARD_SIZE = 3'd3,
    ST_BAD_SQUARE = 3'd4,
    ST_PLAYER_LEN = 3'd5,
    ST_BAD_PLAYER = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    PL_NONE  = 2'd0,
    PL_BLACK = 2'd1,
    PL_WHITE = 2'd2,
    PL_OTHER = 2'd3
  } player_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } in_word_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         text_char;
    status_t            status;
    logic [BOARD_W-1:0] black_squares;
    logic [BOARD_W-1:0] white_squares;
    logic               player_white;
    logic               last;
  } out_word_t;

  // up to two result words per input word, first slot always filled first
  typedef struct packed {
    logic      a_vld;
    logic      b_vld;
    out_word_t a;
    out_word_t b;
  } scan_out_t;

endpackage

### design/brlp_scan.sv
// per-line scan state and the character decode for one word
// depends on brlp_pkg
module brlp_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  brlp_pkg::in_word_t word,
  output brlp_pkg::scan_out_t res
);

  localparam logic [2:0] FLD_KEY    = 3'd0;
  localparam logic [2:0] FLD_BOARD  = 3'd1;
  localparam logic [2:0] FLD_PLAYER = 3'd2;
  localparam logic [2:0] FLD_DONE   = 3'd4;

  logic                          stop_r, stop_nxt;
  logic                          saw_r, saw_nxt;
  logic [2:0]                    seps_r, seps_nxt;
  logic [brlp_pkg::FLEN_W-1:0]   flen_r, flen_nxt;
  logic                          cbad_r, cbad_nxt;
  logic                          sbad_r, sbad_nxt;
  logic [brlp_pkg::BOARD_W-1:0]  blk_r, blk_nxt;
  logic [brlp_pkg::BOARD_W-1:0]  wht_r, wht_nxt;
  brlp_pkg::player_t             pl_r, pl_nxt;

  logic                          txt_vld;
  brlp_pkg::out_word_t           txt, rec;
  brlp_pkg::status_t             st;
  logic [brlp_pkg::BOARD_W-1:0]  sq_bit;

  assign sq_bit = brlp_pkg::BOARD_W'(1) << flen_r[brlp_pkg::IDX_W-1:0];

  always_comb begin
    stop_nxt = stop_r;
    saw_nxt  = saw_r;
    seps_nxt = seps_r;
    flen_nxt = flen_r;
    cbad_nxt = cbad_r;
    sbad_nxt = sbad_r;
    blk_nxt  = blk_r;
    wht_nxt  = wht_r;
    pl_nxt   = pl_r;
    txt_vld  = 1'b0;
    txt      = '0;
    rec      = '0;
    st       = brlp_pkg::ST_ENTRY;

    if (!stop_r) begin
      if (word.ch inside {brlp_pkg::CH_HASH, brlp_pkg::CH_NL, brlp_pkg::CH_NUL}) begin
        stop_nxt = 1'b1;
      end else if (word.ch == brlp_pkg::CH_SEP) begin
        saw_nxt = 1'b1;
        if (seps_r == FLD_BOARD && flen_r != brlp_pkg::BOARD_LEN) begin
          sbad_nxt = 1'b1;
        end
        seps_nxt = seps_r + 3'd1;
        if (seps_nxt inside {FLD_BOARD, FLD_PLAYER}) begin
          flen_nxt = '0;
        end
        if (seps_nxt >= FLD_DONE) begin
          stop_nxt = 1'b1;
        end
      end else begin
        saw_nxt = 1'b1;
        case (seps_r)
          FLD_KEY: begin
            txt_vld       = 1'b1;
            txt.kind      = brlp_pkg::KIND_KEY;
            txt.text_char = word.ch;
          end
          FLD_BOARD: begin
            // squares past the board length are only counted
            if (flen_r < brlp_pkg::BOARD_LEN) begin
              if (word.ch == brlp_pkg::CH_B) begin
                blk_nxt = blk_r | sq_bit;
              end else if (word.ch == brlp_pkg::CH_W) begin
                wht_nxt = wht_r | sq_bit;
              end else if (word.ch != brlp_pkg::CH_DOT) begin
                cbad_nxt = 1'b1;
              end
            end
            if (flen_r < brlp_pkg::FLEN_SAT) begin
              flen_nxt = flen_r + brlp_pkg::FLEN_W'(1);
            end
          end
          FLD_PLAYER: begin
            if (flen_r == '0) begin
              if (word.ch == brlp_pkg::CH_B) begin
                pl_nxt = brlp_pkg::PL_BLACK;
              end else if (word.ch == brlp_pkg::CH_W) begin
                pl_nxt = brlp_pkg::PL_WHITE;
              end else begin
                pl_nxt = brlp_pkg::PL_OTHER;
              end
            end
            if (flen_r < brlp_pkg::FLEN_SAT) begin
              flen_nxt = flen_r + brlp_pkg::FLEN_W'(1);
            end
          end
          default: begin
            txt_vld       = 1'b1;
            txt.kind      = brlp_pkg::KIND_DESC;
            txt.text_char = word.ch;
          end
        endcase
      end
    end

    // status checks see the state after this character
    if (!saw_nxt) begin
      st = brlp_pkg::ST_NOT_ENTRY;
    end else if (seps_nxt != FLD_DONE) begin
      st = brlp_pkg::ST_INCOMPLETE;
    end else if (sbad_nxt) begin
      st = brlp_pkg::ST_BOARD_SIZE;
    end else if (cbad_nxt) begin
      st = brlp_pkg::ST_BAD_SQUARE;
    end else if (flen_nxt != brlp_pkg::FLEN_W'(1)) begin
      st = brlp_pkg::ST_PLAYER_LEN;
    end else if (pl_nxt != brlp_pkg::PL_BLACK && pl_nxt != brlp_pkg::PL_WHITE) begin
      st = brlp_pkg::ST_BAD_PLAYER;
    end else begin
      st = brlp_pkg::ST_ENTRY;
    end

    rec.kind   = brlp_pkg::KIND_REC;
    rec.status = st;
    rec.last   = 1'b1;
    if (st == brlp_pkg::ST_ENTRY) begin
      rec.black_squares = blk_nxt;
      rec.white_squares = wht_nxt;
      rec.player_white  = (pl_nxt == brlp_pkg::PL_WHITE);
    end

    if (word.line_end) begin
      stop_nxt = 1'b0;
      saw_nxt  = 1'b0;
      seps_nxt = '0;
      flen_nxt = '0;
      cbad_nxt = 1'b0;
      sbad_nxt = 1'b0;
      blk_nxt  = '0;
      wht_nxt  = '0;
      pl_nxt   = brlp_pkg::PL_NONE;
    end

    res.a_vld = txt_vld || word.line_end;
    res.b_vld = txt_vld && word.line_end;
    res.a     = txt_vld ? txt : rec;
    res.b     = rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r <= 1'b0;
      saw_r  <= 1'b0;
      seps_r <= '0;
      flen_r <= '0;
      cbad_r <= 1'b0;
      sbad_r <= 1'b0;
      blk_r  <= '0;
      wht_r  <= '0;
      pl_r   <= brlp_pkg::PL_NONE;
    end else if (adv) begin
      stop_r <= stop_nxt;
      saw_r  <= saw_nxt;
      seps_r <= seps_nxt;
      flen_r <= flen_nxt;
      cbad_r <= cbad_nxt;
      sbad_r <= sbad_nxt;
      blk_r  <= blk_nxt;
      wht_r  <= wht_nxt;
      pl_r   <= pl_nxt;
    end
  end

endmodule

### design/brlp_outq.sv
// small result queue: two writes and one read per cycle
// depends on brlp_pkg
module brlp_outq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  brlp_pkg::scan_out_t   res,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_ready,
  output brlp_pkg::out_word_t   out_data
);

  brlp_pkg::out_word_t         mem [brlp_pkg::Q_DEPTH];
  logic [brlp_pkg::Q_PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_b;
  logic [brlp_pkg::Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                         push_a, push_b, pop;

  assign push_a    = push && res.a_vld;
  assign push_b    = push && res.b_vld;
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  // room for two words keeps every input word pushable in full
  assign room      = (cnt_r <= brlp_pkg::Q_CNT_W'(brlp_pkg::Q_DEPTH - 2));
  assign wr_b      = wr_r + brlp_pkg::Q_PTR_W'(1);
  assign out_data  = mem[rd_r];

  always_comb begin
    wr_nxt  = wr_r + brlp_pkg::Q_PTR_W'(push_a) + brlp_pkg::Q_PTR_W'(push_b);
    rd_nxt  = rd_r + brlp_pkg::Q_PTR_W'(pop);
    cnt_nxt = cnt_r + brlp_pkg::Q_CNT_W'(push_a) + brlp_pkg::Q_CNT_W'(push_b)
              - brlp_pkg::Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wr_r] <= res.a;
    end
    if (push_b) begin
      mem[wr_b] <= res.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### design/board_record_line_parser.sv
// board record line parser: one character word in per cycle, results out
// first result goes through the input register and then the queue; 1 word per cycle
// sustained while results are drained at the rate they are produced
// a word ending a line on a key/description char makes two results
// synchronous active-low reset empties the queue and clears line state
// depends on brlp_pkg, brlp_scan, brlp_outq
module board_record_line_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  brlp_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output brlp_pkg::out_word_t out_data
);

  // input register
  logic                in_vld_r, in_vld_nxt;
  brlp_pkg::in_word_t  in_word_r, in_word_nxt;

  // word moves from input register through the scan into the queue
  logic                adv;
  logic                room;
  brlp_pkg::scan_out_t scan_res;

  assign adv      = in_vld_r && room;
  // the input register frees up whenever its word moves on
  assign in_ready = !in_vld_r || room;

  always_comb begin
    in_vld_nxt  = in_vld_r;
    in_word_nxt = in_word_r;
    if (in_ready) begin
      in_vld_nxt  = in_valid;
      in_word_nxt = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    in_word_r <= in_word_nxt;
  end

  // line state and character decode
  brlp_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .word  (in_word_r),
    .res   (scan_res)
  );

  // result queue, holds the text word and the record word of a line end
  brlp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (adv),
    .res       (scan_res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a line end always leaves a record word queued
  a_rec_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_word_r.line_end |=> out_valid)
    else $error("line end left no result queued");

  // record words close the line, text words never do
  a_last_on_rec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.kind == brlp_pkg::KIND_REC)))
    else $error("last flag does not match word kind");

  // failed records carry no board or player
  a_clean_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != brlp_pkg::ST_ENTRY |->
      out_data.black_squares == '0 && out_data.white_squares == '0 &&
      !out_data.player_white)
    else $error("error record carries board data");

endmodule
